// File: src/sts_pkg.sv
// Package of constants and helpers for the staggered task tick scheduler.
package sts_pkg;

    localparam int TASK_COUNT   = 10;
    localparam int COUNT_BITS   = 14;
    localparam int PEND_BITS    = 4;
    localparam int QUERY_BITS   = 4;
    localparam int MASK_BITS    = 10;
    localparam int SLOT_COUNT   = 10;
    localparam int SOURCE_COUNT = 2;

    localparam int S_TDATA_BITS = ((QUERY_BITS + 7) / 8) * 8;
    localparam int PAYLOAD_BITS = 3 * MASK_BITS + PEND_BITS;
    localparam int M_TDATA_BITS = ((PAYLOAD_BITS + 7) / 8) * 8;

    localparam int STAGGER_COUNT = 9;

    localparam logic [31:0] PERIOD_TICKS [SLOT_COUNT] = '{
        32'd5, 32'd10, 32'd13, 32'd20, 32'd50,
        32'd100, 32'd200, 32'd500, 32'd1000, 32'd10000
    };

    localparam logic [3:0] STAGGER_TARGET [STAGGER_COUNT] = '{
        4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9
    };

    localparam logic [3:0] STAGGER_SOURCE [STAGGER_COUNT] = '{
        4'd0, 4'd0, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1
    };

    localparam logic [3:0] STAGGER_OFFSET [STAGGER_COUNT] = '{
        4'd2, 4'd3, 4'd4, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9
    };

    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [PEND_BITS-1:0]  pend_t;

    // Advances one task counter and returns it to zero when its period is reached.
    function automatic count_t count_step(input count_t count, input logic inc,
                                          input logic [31:0] period);
        count_t stepped;
        stepped = inc ? count_t'(count + count_t'(1)) : count;
        if (32'(stepped) == period)
        begin
            stepped = '0;
        end
        return stepped;
    endfunction

endpackage

// File: src/staggered_task_tick_scheduler.sv
// Top level of the staggered task tick scheduler.
//
// Every item accepted on the s_ channel is one tick of the task timers and carries
// the index of the task whose pending count is to be reported. Each tick yields one
// item on the m_ channel with the due, overflow and enabled masks and the queried
// pending count, all as they stand after that tick.
// The cfg_ channel writes max_pending and is always ready; the user is to write it only
// while the block is idle, which the block itself does not enforce. All ten counters are
// updated in one pass of logic between the state registers and the result registers, and
// one tick is accepted in every cycle while the receiver keeps up.
// Results sit in an output register backed by a one-item skid register; s_tready
// falls only when both are full, so a stalled receiver holds back at most two results
// before the ticks are held back in turn.
// After reset all counts and pending counts are zero, only task 0 is enabled,
// max_pending is 3 and no result is pending.
module staggered_task_tick_scheduler
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [sts_pkg::S_TDATA_BITS-1:0]  s_tdata,   // query_task
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // due_mask, overflow_mask, enabled_mask, query_pending
    output logic [sts_pkg::M_TDATA_BITS-1:0]  m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sts_pkg::PEND_BITS-1:0]     cfg_data
);

    localparam int PEND_BITS_P1 = sts_pkg::PEND_BITS + 1;

    sts_pkg::count_t                        cnt_reg  [sts_pkg::TASK_COUNT];
    sts_pkg::count_t                        cnt_next [sts_pkg::TASK_COUNT];
    sts_pkg::pend_t                         pend_reg  [sts_pkg::TASK_COUNT];
    sts_pkg::pend_t                         pend_next [sts_pkg::TASK_COUNT];
    logic [sts_pkg::TASK_COUNT-1:0]         en_reg;
    logic [sts_pkg::TASK_COUNT-1:0]         en_next;
    sts_pkg::pend_t                         max_pend_reg;

    sts_pkg::count_t                        src_cnt [sts_pkg::SOURCE_COUNT];
    logic [sts_pkg::TASK_COUNT-1:0]         hit;
    logic [sts_pkg::TASK_COUNT-1:0]         inc;
    logic                                   check_run;
    logic [sts_pkg::MASK_BITS-1:0]          due_mask;
    logic [sts_pkg::MASK_BITS-1:0]          ovf_mask;
    logic [sts_pkg::MASK_BITS-1:0]          ena_mask;
    sts_pkg::pend_t                         query_pend;
    logic [sts_pkg::PAYLOAD_BITS-1:0]       result;

    logic                                   out_valid_reg;
    logic [sts_pkg::PAYLOAD_BITS-1:0]       out_data_reg;
    logic                                   skid_valid_reg;
    logic [sts_pkg::PAYLOAD_BITS-1:0]       skid_data_reg;

    logic                                   in_fire;
    logic                                   out_fire;

    assign s_tready  = !skid_valid_reg;
    assign in_fire   = s_tvalid && s_tready;
    assign m_tvalid  = out_valid_reg;
    assign out_fire  = out_valid_reg && m_tready;
    assign cfg_ready = 1'b1;
    assign m_tdata   = sts_pkg::M_TDATA_BITS'(out_data_reg);

    always_comb
    begin
        logic                       gap;
        logic [PEND_BITS_P1-1:0]    p;
        sts_pkg::count_t            stepped;

        for (int s = 0; s < sts_pkg::SOURCE_COUNT; s++)
        begin
            src_cnt[s] = sts_pkg::count_step(cnt_reg[s], en_reg[s], sts_pkg::PERIOD_TICKS[s]);
        end

        hit = '0;
        for (int r = 0; r < sts_pkg::STAGGER_COUNT; r++)
        begin
            if ((32'(sts_pkg::STAGGER_TARGET[r]) < 32'(sts_pkg::TASK_COUNT)) &&
                (32'(sts_pkg::STAGGER_SOURCE[r]) < 32'(sts_pkg::SOURCE_COUNT)) &&
                (32'(src_cnt[sts_pkg::STAGGER_SOURCE[r][0]]) ==
                 32'(sts_pkg::STAGGER_OFFSET[r])))
            begin
                hit[sts_pkg::STAGGER_TARGET[r]] = 1'b1;
            end
        end

        // The stagger check runs while any of tasks 1 to 9 is disabled in the enable register.
        check_run = !(&en_reg[sts_pkg::TASK_COUNT-1:1]);
        en_next   = en_reg | (check_run ? hit : '0);

        gap    = 1'b0;
        inc[0] = en_reg[0];
        for (int i = 1; i < sts_pkg::TASK_COUNT; i++)
        begin
            inc[i] = en_reg[i] || (gap && hit[i]);
            gap    = gap || !en_reg[i];
        end

        due_mask = '0;
        ovf_mask = '0;
        ena_mask = '0;
        for (int i = 0; i < sts_pkg::TASK_COUNT; i++)
        begin
            stepped      = inc[i] ? sts_pkg::count_t'(cnt_reg[i] + sts_pkg::count_t'(1))
                                  : cnt_reg[i];
            cnt_next[i]  = stepped;
            pend_next[i] = pend_reg[i];
            p            = '0;
            if (32'(stepped) == sts_pkg::PERIOD_TICKS[i])
            begin
                cnt_next[i] = '0;
                due_mask[i] = 1'b1;
                p = PEND_BITS_P1'(pend_reg[i]) + PEND_BITS_P1'(1);
                if (p > PEND_BITS_P1'(max_pend_reg))
                begin
                    p           = '0;
                    ovf_mask[i] = 1'b1;
                end
                pend_next[i] = p[sts_pkg::PEND_BITS-1:0];
            end
            ena_mask[i] = en_next[i];
        end

        query_pend = '0;
        for (int i = 0; i < sts_pkg::TASK_COUNT; i++)
        begin
            if (s_tdata[sts_pkg::QUERY_BITS-1:0] == sts_pkg::QUERY_BITS'(i))
            begin
                query_pend = pend_next[i];
            end
        end

        result = {query_pend, ena_mask, ovf_mask, due_mask};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < sts_pkg::TASK_COUNT; i++)
            begin
                cnt_reg[i]  <= '0;
                pend_reg[i] <= '0;
            end
            en_reg       <= sts_pkg::TASK_COUNT'(1);
            max_pend_reg <= sts_pkg::PEND_BITS'(3);
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                max_pend_reg <= cfg_data;
            end
            if (in_fire)
            begin
                for (int i = 0; i < sts_pkg::TASK_COUNT; i++)
                begin
                    cnt_reg[i]  <= cnt_next[i];
                    pend_reg[i] <= pend_next[i];
                end
                en_reg <= en_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                if (!out_valid_reg || out_fire)
                begin
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    skid_valid_reg <= 1'b1;
                end
            end
            else if (out_fire)
            begin
                if (skid_valid_reg)
                begin
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            if (!out_valid_reg || out_fire)
            begin
                out_data_reg <= result;
            end
            else
            begin
                skid_data_reg <= result;
            end
        end
        else if (out_fire && skid_valid_reg)
        begin
            out_data_reg <= skid_data_reg;
        end
    end

endmodule
